@@ design/xrw_pkg.sv @@
// ----------------------------------------------------------------------------
// xrw_pkg
// Shared constants, command codes and the mixing function for the ring/Weyl
// random number generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrw_pkg;

  localparam int WORD_W         = 64;
  localparam int CMD_W          = 2;
  localparam int RING_DEPTH_DEF = 64;
  localparam int LAG            = 53;
  localparam int T_SHL          = 33;
  localparam int T_SHR          = 26;
  localparam int V_SHL          = 27;
  localparam int V_SHR          = 29;
  localparam int WEYL_SHR       = 27;
  localparam int OUT_DEPTH      = 4;

  localparam logic [WORD_W-1:0] WEYL_INC_RESET = 64'h61C8_8646_80B5_83EB;

  localparam logic [CMD_W-1:0] CMD_GEN       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_RING = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_WEYL = 2'd2;

  // left shift-xor followed by right shift-xor
  function automatic logic [WORD_W-1:0] shuffle_pair(input logic [WORD_W-1:0] x,
                                                     input int left,
                                                     input int right);
    logic [WORD_W-1:0] y;
    y = x ^ (x << left);
    y = y ^ (y >> right);
    return y;
  endfunction

endpackage

`default_nettype wire

@@ design/xrw_ring.sv @@
// ----------------------------------------------------------------------------
// xrw_ring
// Ring word store: synchronous memory with two read ports and one write port,
// per-entry valid bits for the all-zero reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module xrw_ring #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic      [WIDTH-1:0]         rd_a_data,
  output logic      [WIDTH-1:0]         rd_b_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [WIDTH-1:0] mem_a;
  logic [WIDTH-1:0] mem_b;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic             valid_a;
  logic             valid_b;

  // write that lands on the same edge as the read
  logic             fwd_en;
  logic [AW-1:0]    fwd_addr;
  logic [WIDTH-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_a    <= mem[rd_a_addr];
    mem_b    <= mem[rd_b_addr];
    addr_a   <= rd_a_addr;
    addr_b   <= rd_b_addr;
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      fwd_en  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_a <= valid[rd_a_addr];
      valid_b <= valid[rd_b_addr];
      fwd_en  <= wr_en;
    end
  end

  always_comb begin
    if (fwd_en && fwd_addr == addr_a) begin
      rd_a_data = fwd_data;
    end else if (valid_a) begin
      rd_a_data = mem_a;
    end else begin
      rd_a_data = '0;
    end
    if (fwd_en && fwd_addr == addr_b) begin
      rd_b_data = fwd_data;
    end else if (valid_b) begin
      rd_b_data = mem_b;
    end else begin
      rd_b_data = '0;
    end
  end

endmodule

`default_nettype wire

@@ design/xorshift_ring_weyl_rng_core.sv @@
// ----------------------------------------------------------------------------
// xorshift_ring_weyl_rng_core
// 64-bit xorshift generator over a ring of words, combined with a Weyl sum.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries cmd, word_index and load_value.
// cmd generate produces one random_value on the output channel
// (out_valid/out_stall); ring loads and Weyl loads produce nothing.
// weyl_increment is written through cfg_write/cfg_data only while idle
// by the user; the block does not enforce it. Throughput: one transaction
// per cycle on either channel unless stalled. Each cycle the ring memory
// serves two reads (pointer word and lagged word) and one write-back;
// same-entry overlap between neighbouring items is forwarded. A generate
// result passes through the second stage and a 4-entry output queue;
// in_stall rises when the queue plus the item in flight would reach 4, so
// a stalled receiver only holds up the input once the queue fills. Nothing
// is lost while stalled. Reset (rst, synchronous): ring reads as zero
// through per-entry valid bits (no clearing pass), pointer 63, Weyl sum
// 0, increment to default. in_stall is held high during reset.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift_ring_weyl_rng_core #(
  parameter int RING_DEPTH = xrw_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [xrw_pkg::WORD_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [xrw_pkg::CMD_W-1:0]     cmd,
  input  wire logic [$clog2(RING_DEPTH)-1:0] word_index,
  input  wire logic [xrw_pkg::WORD_W-1:0]    load_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [xrw_pkg::WORD_W-1:0]    random_value
);

  import xrw_pkg::*;

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int QAW = $clog2(OUT_DEPTH);
  localparam int QCW = $clog2(OUT_DEPTH + 1);

  logic              accept;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     ptr_next;
  logic [AW-1:0]     lag_addr;
  logic [WORD_W-1:0] weyl;
  logic [WORD_W-1:0] weyl_next;
  logic [WORD_W-1:0] inc;

  // second stage: memory data arrives
  logic              s1_gen;
  logic              s1_load;
  logic [AW-1:0]     s1_addr;
  logic [WORD_W-1:0] s1_value;
  logic [WORD_W-1:0] s1_mix;

  logic [WORD_W-1:0] t_word;
  logic [WORD_W-1:0] v_word;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] result;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  logic [WORD_W-1:0] queue [OUT_DEPTH];
  logic [QAW-1:0]    q_wr;
  logic [QAW-1:0]    q_rd;
  logic [QCW-1:0]    q_count;
  logic              pop;

  assign accept    = in_valid && !in_stall;
  assign ptr_next  = ptr + 1'b1;
  assign lag_addr  = ptr_next - AW'(LAG);
  assign weyl_next = weyl + inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= AW'(RING_DEPTH - 1);
      weyl    <= '0;
      inc     <= WEYL_INC_RESET;
      s1_gen  <= 1'b0;
      s1_load <= 1'b0;
    end else begin
      if (cfg_write) begin
        inc <= cfg_data;
      end
      if (accept) begin
        case (cmd)
          CMD_GEN: begin
            ptr  <= ptr_next;
            weyl <= weyl_next;
          end
          CMD_LOAD_WEYL: begin
            weyl <= load_value;
          end
          default: begin
          end
        endcase
      end
      s1_gen  <= accept && cmd == CMD_GEN;
      s1_load <= accept && cmd == CMD_LOAD_RING;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= (cmd == CMD_GEN) ? ptr_next : word_index;
    s1_value <= load_value;
    s1_mix   <= weyl_next ^ (weyl_next >> WEYL_SHR);
  end

  xrw_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (WORD_W)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .rd_a_addr (ptr_next),
    .rd_b_addr (lag_addr),
    .rd_a_data (t_word),
    .rd_b_data (v_word),
    .wr_en     (wr_en),
    .wr_addr   (s1_addr),
    .wr_data   (wr_data)
  );

  assign mixed   = shuffle_pair(t_word, T_SHL, T_SHR) ^ shuffle_pair(v_word, V_SHL, V_SHR);
  assign result  = mixed + s1_mix;
  assign wr_en   = s1_gen || s1_load;
  assign wr_data = s1_gen ? mixed : s1_value;

  // output queue
  assign out_valid    = q_count != '0;
  assign random_value = queue[q_rd];
  assign pop          = out_valid && !out_stall;
  assign in_stall     = rst || (q_count + QCW'(s1_gen)) > QCW'(OUT_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (s1_gen) begin
      queue[q_wr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (s1_gen) begin
        q_wr <= q_wr + 1'b1;
      end
      if (pop) begin
        q_rd <= q_rd + 1'b1;
      end
      q_count <= q_count + QCW'(s1_gen) - QCW'(pop);
    end
  end

endmodule

`default_nettype wire

@@ design/xrw_checker.sv @@
// ----------------------------------------------------------------------------
// xrw_checker
// Port-level checks for the ring/Weyl random number generator.
// ----------------------------------------------------------------------------
`default_nettype none

module xrw_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [xrw_pkg::CMD_W-1:0]  cmd,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [xrw_pkg::WORD_W-1:0] random_value
);

  import xrw_pkg::*;

  logic gen_acc;
  assign gen_acc = in_valid && !in_stall && cmd == CMD_GEN;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_value))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output not empty after reset");

  // every generate transaction reaches the output through the second stage and the queue
  a_gen_arrives: assert property (@(posedge clk) disable iff (rst)
    gen_acc |=> ##1 out_valid)
    else $error("generate transaction did not reach the output");

  // no result without a generate transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(gen_acc) |=> !out_valid)
    else $error("result appeared without a generate transaction");

endmodule

bind xorshift_ring_weyl_rng_core xrw_checker u_xrw_checker (.*);

`default_nettype wire
